// ===== sv/bsm_pkg.sv =====
// Package for the bank-switching mapper with scanline interrupt counter.
// Holds the item codes, the register decode codes and the result struct.
// No dependencies.
package bsm_pkg;

  // Kind of item presented on the input channel.
  typedef enum logic [1:0] {
    ACT_CPU_WRITE = 2'd0,
    ACT_SCANLINE  = 2'd1,
    ACT_PRG_LOOK  = 2'd2,
    ACT_CHR_LOOK  = 2'd3
  } action_e;

  // CPU register decode: address bits 14:13 and bit 0, with bit 15 set.
  typedef enum logic [2:0] {
    REG_BANK_SELECT = 3'b000,
    REG_BANK_DATA   = 3'b001,
    REG_MIRROR      = 3'b010,
    REG_IRQ_LATCH   = 3'b100,
    REG_IRQ_CLEAR   = 3'b101,
    REG_IRQ_DISABLE = 3'b110,
    REG_IRQ_ENABLE  = 3'b111
  } reg_sel_e;

  localparam int unsigned BankW     = 8;
  localparam int unsigned BankRegs  = 8;
  localparam int unsigned CountW    = 9;
  localparam int unsigned PrgSwapBit = 6;
  localparam int unsigned ChrSwapBit = 7;
  localparam logic [CountW-1:0] CountReset = 9'd32;

  typedef struct packed {
    logic [BankW-1:0] bank_number;
    logic             irq_line;
    logic             mirror_horizontal;
  } result_t;

endpackage

// ===== sv/bsm_core.sv =====
// Mapper state and the single-pass logic that applies one beat to it.
// Depends on bsm_pkg.
module bsm_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [1:0]                    action_i,
  input  logic [15:0]                   address_i,
  input  logic [7:0]                    data_i,
  input  logic                          cfg_we_i,
  input  logic [bsm_pkg::CountW-1:0]    cfg_wdata_i,
  output bsm_pkg::result_t              result_o
);
  import bsm_pkg::*;

  logic [BankW-1:0]  bank_regs_q [BankRegs];
  logic [BankW-1:0]  bank_select_q, bank_select_d;
  logic              mirror_q, mirror_d;
  logic              irq_en_q, irq_en_d;
  logic [BankW-1:0]  irq_reload_q, irq_reload_d;
  logic [BankW-1:0]  irq_count_q, irq_count_d;
  logic              irq_pend_q, irq_pend_d;
  logic [CountW-1:0] bank_count_q;

  logic              bank_we;
  logic [2:0]        bank_widx;
  logic [BankW-1:0]  bank_out;
  logic [BankW-1:0]  prg_last, prg_second;
  logic [2:0]        chr_unit;
  logic [2:0]        chr_idx;
  logic [BankW-1:0]  chr_reg;
  reg_sel_e          reg_sel;

  assign reg_sel    = reg_sel_e'({address_i[14:13], address_i[0]});
  assign bank_widx  = bank_select_q[2:0];
  assign prg_last   = bank_count_q[BankW-1:0] - 8'd1;
  assign prg_second = bank_count_q[BankW-1:0] - 8'd2;
  assign chr_unit   = address_i[12:10] ^ {bank_select_q[ChrSwapBit], 2'b00};
  assign chr_idx    = chr_unit[2] ? (3'd2 + {1'b0, chr_unit[1:0]}) : {2'b00, chr_unit[1]};
  assign chr_reg    = bank_regs_q[chr_idx];

  always_comb begin
    bank_select_d = bank_select_q;
    mirror_d      = mirror_q;
    irq_en_d      = irq_en_q;
    irq_reload_d  = irq_reload_q;
    irq_count_d   = irq_count_q;
    irq_pend_d    = irq_pend_q;
    bank_we       = 1'b0;
    bank_out      = '0;
    case (action_e'(action_i))
      ACT_CPU_WRITE: begin
        if (address_i[15]) begin
          unique case (reg_sel)
            REG_BANK_SELECT: bank_select_d = data_i;
            REG_BANK_DATA:   bank_we       = 1'b1;
            REG_MIRROR:      mirror_d      = data_i[0];
            REG_IRQ_LATCH:   irq_reload_d  = data_i;
            REG_IRQ_CLEAR:   irq_count_d   = '0;
            REG_IRQ_DISABLE: begin
              irq_en_d   = 1'b0;
              irq_pend_d = 1'b0;
            end
            REG_IRQ_ENABLE:  irq_en_d      = 1'b1;
            default: ;
          endcase
        end
      end
      ACT_SCANLINE: begin
        irq_count_d = (irq_count_q == '0) ? irq_reload_q : irq_count_q - 8'd1;
        if (irq_en_q && (irq_count_d == '0)) begin
          irq_pend_d = 1'b1;
        end
      end
      ACT_PRG_LOOK: begin
        case (address_i[14:13])
          2'd0:    bank_out = bank_select_q[PrgSwapBit] ? prg_second : bank_regs_q[6];
          2'd1:    bank_out = bank_regs_q[7];
          2'd2:    bank_out = bank_select_q[PrgSwapBit] ? bank_regs_q[6] : prg_second;
          default: bank_out = prg_last;
        endcase
      end
      default: begin
        // A 2KB window forces the low bit from the unit within the window.
        bank_out = chr_unit[2] ? chr_reg : {chr_reg[BankW-1:1], chr_unit[0]};
      end
    endcase
  end

  assign result_o.bank_number       = bank_out;
  assign result_o.irq_line          = irq_pend_d;
  assign result_o.mirror_horizontal = mirror_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BankRegs; i++) begin
        bank_regs_q[i] <= '0;
      end
      bank_select_q <= '0;
      mirror_q      <= 1'b1;
      irq_en_q      <= 1'b0;
      irq_reload_q  <= '0;
      irq_count_q   <= '0;
      irq_pend_q    <= 1'b0;
      bank_count_q  <= CountReset;
    end else begin
      if (cfg_we_i) begin
        bank_count_q <= cfg_wdata_i;
      end
      if (step_i) begin
        if (bank_we) begin
          bank_regs_q[bank_widx] <= data_i;
        end
        bank_select_q <= bank_select_d;
        mirror_q      <= mirror_d;
        irq_en_q      <= irq_en_d;
        irq_reload_q  <= irq_reload_d;
        irq_count_q   <= irq_count_d;
        irq_pend_q    <= irq_pend_d;
      end
    end
  end

endmodule

// ===== sv/bank_switch_mapper_scanline_irq_unit.sv =====
// Top level of the bank-switching mapper with scanline interrupt counter.
// Holds the input and result registers; depends on bsm_pkg and bsm_core.
//
// Usage: each beat on the input channel is one of four items, chosen by
// action_i: a CPU register write (address_i, data_i), a scanline tick, a
// PRG lookup or a CHR lookup (address_i). Every input beat yields exactly
// one result beat carrying the resolved bank (zero for writes and ticks),
// the interrupt request level and the mirroring flag after that item.
// The accepting edge loads the input register; once the result slot is free
// or being emptied, an edge carries the item through the mapper logic into
// the result register. Throughput is one item per cycle while the receiver
// does not stall; the mapper state in bsm_core is updated as each item moves
// into the result register. When the receiver stalls, the result register
// holds, the input register takes one more beat, and then input ready drops
// until the result is taken. The user must write the bank count through
// cfg_we_i / cfg_wdata_i only while the block is idle; the block does not
// enforce this. Reset empties both registers, clears the bank registers and
// interrupt state, selects horizontal mirroring, sets the bank count to 32.
module bank_switch_mapper_scanline_irq_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 action_i,
  input  logic [15:0]                address_i,
  input  logic [7:0]                 data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 bank_number_o,
  output logic                       irq_line_o,
  output logic                       mirror_horizontal_o,
  input  logic                       cfg_we_i,
  input  logic [bsm_pkg::CountW-1:0] cfg_wdata_i
);
  import bsm_pkg::*;

  // Input register: control bit with reset, payload without.
  logic        in_valid_q;
  logic [1:0]  action_q;
  logic [15:0] address_q;
  logic [7:0]  data_q;

  // Result register.
  logic        out_valid_q;
  result_t     result_q;
  result_t     result_d;

  // The item in the input register advances when the result slot is free
  // or is being emptied in this cycle.
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  bsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .action_i    (action_q),
    .address_i   (address_q),
    .data_i      (data_q),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      action_q  <= action_i;
      address_q <= address_i;
      data_q    <= data_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign bank_number_o       = result_q.bank_number;
  assign irq_line_o          = result_q.irq_line;
  assign mirror_horizontal_o = result_q.mirror_horizontal;

endmodule
